// File: src/hsv_to_rgb_converter_macros.svh
// Assertion macros for the HSV to RGB converter top level.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH
`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define HSVRGB_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hsv_to_rgb_converter: check failed");
// prop must never hold at a clock edge outside reset
`define HSVRGB_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("hsv_to_rgb_converter: forbidden condition");
`else
`define HSVRGB_ASSERT(lbl, clk, rst_n, prop)
`define HSVRGB_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

// File: src/hsvrgb_pkg.sv
// Shared constants and stage payload types for the HSV to RGB converter.
package hsvrgb_pkg;

  localparam logic [14:0] HUE_FULL   = 15'd23040;  // 360 degrees in 1/64 degree
  localparam logic [11:0] HUE_SECTOR = 12'd3840;   // 60 degrees
  localparam logic [8:0]  Q_ONE      = 9'd256;     // 1.0 in Q1.8
  localparam logic [19:0] K_ONE      = 20'd983040; // 1.0 in Q1.8 times HUE_SECTOR
  localparam logic [12:0] RECIP15    = 13'd4369;   // ceil-free 2^16/15 reciprocal

  // 60-degree hue sectors
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // after sector split
  typedef struct packed {
    sector_t     sector;
    logic [11:0] rem;
    logic [8:0]  sat;
    logic [8:0]  val;
    logic [8:0]  alpha;
  } s1_t;

  // after saturation products
  typedef struct packed {
    sector_t     sector;
    logic [8:0]  val;
    logic [8:0]  alpha;
    logic [8:0]  p;
    logic [19:0] sr;   // S * R
    logic [19:0] st;   // S * (3840 - R)
  } s2_t;

  // after brightness products
  typedef struct packed {
    sector_t     sector;
    logic [8:0]  val;
    logic [8:0]  alpha;
    logic [8:0]  p;
    logic [27:0] q_num;
    logic [27:0] t_num;
  } s3_t;

endpackage

// File: src/hsvrgb_sector.sv
// Stage 1: clamp inputs, wrap hue and split it into sector and remainder.
module hsvrgb_sector (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [14:0]       hue,
  input  logic [8:0]        sat,
  input  logic [8:0]        val,
  input  logic [8:0]        alpha,
  output logic              s1_vld_r,
  output hsvrgb_pkg::s1_t   s1_r
);
  import hsvrgb_pkg::*;

  logic [14:0] hue_w;
  logic [14:0] base;
  logic [14:0] rem_full;
  sector_t     sector;
  s1_t         s1_nxt;

  // full circle and beyond wraps to zero
  assign hue_w = (hue >= HUE_FULL) ? 15'd0 : hue;

  // sector by threshold compare, base is sector * 3840
  always_comb begin
    if (hue_w >= 15'd19200) begin
      sector = SEC_MAG_RED;
      base   = 15'd19200;
    end else if (hue_w >= 15'd15360) begin
      sector = SEC_BLU_MAG;
      base   = 15'd15360;
    end else if (hue_w >= 15'd11520) begin
      sector = SEC_CYN_BLU;
      base   = 15'd11520;
    end else if (hue_w >= 15'd7680) begin
      sector = SEC_GRN_CYN;
      base   = 15'd7680;
    end else if (hue_w >= {3'd0, HUE_SECTOR}) begin
      sector = SEC_YEL_GRN;
      base   = {3'd0, HUE_SECTOR};
    end else begin
      sector = SEC_RED_YEL;
      base   = 15'd0;
    end
  end

  assign rem_full = hue_w - base;

  always_comb begin
    s1_nxt.sector = sector;
    s1_nxt.rem    = rem_full[11:0];
    s1_nxt.sat    = (sat > Q_ONE) ? Q_ONE : sat;
    s1_nxt.val    = (val > Q_ONE) ? Q_ONE : val;
    s1_nxt.alpha  = alpha;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
  end

endmodule

// File: src/hsvrgb_scale.sv
// Stages 2 and 3: saturation products, then brightness products for q and t.
module hsvrgb_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s1_vld,
  input  hsvrgb_pkg::s1_t   s1,
  output logic              s3_vld_r,
  output hsvrgb_pkg::s3_t   s3_r
);
  import hsvrgb_pkg::*;

  logic        s2_vld_r;
  s2_t         s2_r;
  s2_t         s2_nxt;
  s3_t         s3_nxt;
  logic [20:0] sr_full;
  logic [20:0] st_full;
  logic [11:0] rem_inv;
  logic [17:0] p_full;
  logic [8:0]  sat_inv;
  logic [19:0] kq;
  logic [19:0] kt;
  logic [28:0] q_full;
  logic [28:0] t_full;

  // stage 2: S*R, S*(3840-R), and p = V*(256-S)/256
  assign rem_inv = HUE_SECTOR - s1.rem;
  assign sat_inv = Q_ONE - s1.sat;
  assign sr_full = s1.sat * s1.rem;
  assign st_full = s1.sat * rem_inv;
  assign p_full  = s1.val * sat_inv;

  always_comb begin
    s2_nxt.sector = s1.sector;
    s2_nxt.val    = s1.val;
    s2_nxt.alpha  = s1.alpha;
    s2_nxt.p      = p_full[16:8];
    s2_nxt.sr     = sr_full[19:0];
    s2_nxt.st     = st_full[19:0];
  end

  // stage 3: numerators V*(983040 - S*R) and V*(983040 - S*(3840-R))
  assign kq     = K_ONE - s2_r.sr;
  assign kt     = K_ONE - s2_r.st;
  assign q_full = s2_r.val * kq;
  assign t_full = s2_r.val * kt;

  always_comb begin
    s3_nxt.sector = s2_r.sector;
    s3_nxt.val    = s2_r.val;
    s3_nxt.alpha  = s2_r.alpha;
    s3_nxt.p      = s2_r.p;
    s3_nxt.q_num  = q_full[27:0];
    s3_nxt.t_num  = t_full[27:0];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld;
      s3_vld_r <= s2_vld_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
    s3_r <= s3_nxt;
  end

endmodule

// File: src/hsvrgb_select.sv
// Stage 4: divide q and t numerators by 983040 and route channels by sector.
module hsvrgb_select (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              s3_vld,
  input  hsvrgb_pkg::s3_t   s3,
  output logic              out_vld_r,
  output logic [8:0]        red_r,
  output logic [8:0]        green_r,
  output logic [8:0]        blue_r,
  output logic [8:0]        alpha_r
);
  import hsvrgb_pkg::*;

  logic [12:0] yq;
  logic [12:0] yt;
  logic [25:0] q_prod;
  logic [25:0] t_prod;
  logic [8:0]  q;
  logic [8:0]  t;
  logic [8:0]  p;
  logic [8:0]  v;
  logic [8:0]  red_nxt;
  logic [8:0]  green_nxt;
  logic [8:0]  blue_nxt;

  // 983040 = 15 * 2^16: shift, then divide by 15 as (y+1)*4369 >> 16
  // (exact for y up to 3840)
  assign yq     = {1'b0, s3.q_num[27:16]} + 13'd1;
  assign yt     = {1'b0, s3.t_num[27:16]} + 13'd1;
  assign q_prod = yq * RECIP15;
  assign t_prod = yt * RECIP15;
  assign q      = q_prod[24:16];
  assign t      = t_prod[24:16];
  assign p      = s3.p;
  assign v      = s3.val;

  // channel routing; zero saturation gives p = q = t = v, so grey falls out
  always_comb begin
    case (s3.sector)
      SEC_RED_YEL: begin red_nxt = v; green_nxt = t; blue_nxt = p; end
      SEC_YEL_GRN: begin red_nxt = q; green_nxt = v; blue_nxt = p; end
      SEC_GRN_CYN: begin red_nxt = p; green_nxt = v; blue_nxt = t; end
      SEC_CYN_BLU: begin red_nxt = p; green_nxt = q; blue_nxt = v; end
      SEC_BLU_MAG: begin red_nxt = t; green_nxt = p; blue_nxt = v; end
      default:     begin red_nxt = v; green_nxt = p; blue_nxt = q; end
    endcase
  end

  // output strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s3_vld;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    blue_r  <= blue_nxt;
    alpha_r <= s3.alpha;
  end

endmodule

// File: src/hsv_to_rgb_converter.sv
// HSV to RGB converter, four-stage pipeline: sector split, saturation products,
// brightness products, divide and route. One pixel is taken every clock cycle
// (busy never rises) and its RGBA result appears on the out_ ports once it has
// passed all four register stages, flagged by a one-cycle out_valid strobe. The
// receiver cannot stall the block; results must be captured in the strobe cycle.
// Throughput is one transaction per cycle.
`include "hsv_to_rgb_converter_macros.svh"
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [14:0] in_hue,
  input  logic [8:0]  in_saturation,
  input  logic [8:0]  in_brightness,
  input  logic [8:0]  in_alpha_in,
  output logic        out_valid,
  output logic [8:0]  out_red,
  output logic [8:0]  out_green,
  output logic [8:0]  out_blue,
  output logic [8:0]  out_alpha_out
);
  import hsvrgb_pkg::*;

  logic in_vld;
  logic s1_vld;
  s1_t  s1;
  logic s3_vld;
  s3_t  s3;

  // fully pipelined, never busy
  assign busy   = 1'b0;
  assign in_vld = start & ~busy;

  hsvrgb_sector u_sector (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_vld),
    .hue      (in_hue),
    .sat      (in_saturation),
    .val      (in_brightness),
    .alpha    (in_alpha_in),
    .s1_vld_r (s1_vld),
    .s1_r     (s1)
  );

  hsvrgb_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_vld   (s1_vld),
    .s1       (s1),
    .s3_vld_r (s3_vld),
    .s3_r     (s3)
  );

  hsvrgb_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_vld    (s3_vld),
    .s3        (s3),
    .out_vld_r (out_valid),
    .red_r     (out_red),
    .green_r   (out_green),
    .blue_r    (out_blue),
    .alpha_r   (out_alpha_out)
  );

  // every accepted transaction comes out with an out_valid strobe
  `HSVRGB_ASSERT(a_latency, clk, rst_n, in_vld |-> ##4 out_valid)
  // no strobe without an earlier accepted transaction
  `HSVRGB_ASSERT(a_no_phantom, clk, rst_n, !in_vld |-> ##4 !out_valid)
  // channels never exceed 1.0
  `HSVRGB_NEVER(a_range, clk, rst_n,
    out_valid && (out_red > Q_ONE || out_green > Q_ONE || out_blue > Q_ONE))
  // alpha rides along with its pixel
  `HSVRGB_ASSERT(a_alpha, clk, rst_n,
    out_valid |-> out_alpha_out == $past(in_alpha_in, 4))

endmodule

// File: tb/tb_hsv_to_rgb_converter.sv
// Self-checking testbench for the HSV to RGB converter: directed corners, then random pixels.
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter;
  import hsvrgb_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_PIXELS = 1100;
  localparam int PRINT_CAP    = 100;

  // one HSVA pixel waiting to be sent, with the idle gap before it
  typedef struct {
    logic [14:0] hue;
    logic [8:0]  sat;
    logic [8:0]  val;
    logic [8:0]  alpha;
    int          gap;
  } hsv_pixel_t;

  typedef struct packed {
    logic [8:0] red;
    logic [8:0] green;
    logic [8:0] blue;
    logic [8:0] alpha;
  } rgba_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [14:0] in_hue = '0;
  logic [8:0]  in_saturation = '0;
  logic [8:0]  in_brightness = '0;
  logic [8:0]  in_alpha_in = '0;
  logic        out_valid;
  logic [8:0]  out_red;
  logic [8:0]  out_green;
  logic [8:0]  out_blue;
  logic [8:0]  out_alpha_out;

  hsv_pixel_t pending_pixels[$];
  rgba_t      expected_rgba[$];
  hsv_pixel_t next_pixel;
  logic       have_next = 1'b0;
  int         idle_left = 0;
  int         reset_cnt = 0;
  int         cycle_cnt = 0;
  int         mismatch_cnt = 0;
  int         sent_cnt = 0;
  int         checked_cnt = 0;

  hsv_to_rgb_converter uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_hue        (in_hue),
    .in_saturation (in_saturation),
    .in_brightness (in_brightness),
    .in_alpha_in   (in_alpha_in),
    .out_valid     (out_valid),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha_out (out_alpha_out)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected RGBA for one HSVA pixel
  function automatic rgba_t hsv_pixel_to_rgba(input logic [14:0] hue, input logic [8:0] sat_in,
                                              input logic [8:0] val_in, input logic [8:0] alpha);
    rgba_t            px;
    logic [8:0]       s;
    logic [8:0]       v;
    logic [14:0]      h;
    sector_t          sec;
    longint unsigned  ss, vv, rr, p, q, t;
    s = (sat_in > Q_ONE) ? Q_ONE : sat_in;
    v = (val_in > Q_ONE) ? Q_ONE : val_in;
    px.red   = v;
    px.green = v;
    px.blue  = v;
    px.alpha = alpha;
    if (s != 9'd0) begin
      // full circle and beyond wraps to red
      h   = (hue >= HUE_FULL) ? 15'd0 : hue;
      sec = sector_t'(3'(h / HUE_SECTOR));
      ss  = s;
      vv  = v;
      rr  = h % HUE_SECTOR;
      p = (vv * (longint'(Q_ONE) - ss)) / Q_ONE;
      q = (vv * (longint'(K_ONE) - ss * rr)) / K_ONE;
      t = (vv * (longint'(K_ONE) - ss * (longint'(HUE_SECTOR) - rr))) / K_ONE;
      case (sec)
        SEC_RED_YEL: begin px.red = v;     px.green = 9'(t); px.blue = 9'(p); end
        SEC_YEL_GRN: begin px.red = 9'(q); px.green = v;     px.blue = 9'(p); end
        SEC_GRN_CYN: begin px.red = 9'(p); px.green = v;     px.blue = 9'(t); end
        SEC_CYN_BLU: begin px.red = 9'(p); px.green = 9'(q); px.blue = v;     end
        SEC_BLU_MAG: begin px.red = 9'(t); px.green = 9'(p); px.blue = v;     end
        default: begin     px.red = v;     px.green = 9'(p); px.blue = 9'(q); end
      endcase
    end
    return px;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= PRINT_CAP)
      $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
  endtask

  task automatic queue_pixel(input int hue, input int sat, input int val, input int alpha,
                             input int gap);
    hsv_pixel_t px;
    px.hue   = 15'(hue);
    px.sat   = 9'(sat);
    px.val   = 9'(val);
    px.alpha = 9'(alpha);
    px.gap   = gap;
    pending_pixels.push_back(px);
  endtask

  // mostly short gaps, a few long ones; none at all in quiet phases
  function automatic int pick_gap(input logic idle_phase);
    int roll;
    if (!idle_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Q1.8 value: mostly in range, with the ends and over-range values
  function automatic int pick_q18();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return 256;
    if (roll == 2) return $urandom_range(0, 511);
    return $urandom_range(0, 256);
  endfunction

  function automatic int pick_hue();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 5) return $urandom_range(0, 23039);
    if (roll < 7) return $urandom_range(0, 6) * 3840 + $urandom_range(0, 4) - 2;
    if (roll < 9) return $urandom_range(0, 32767);
    return $urandom_range(23040, 32767);
  endfunction

  // synchronous reset, held for the first cycles only
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (reset_cnt < RESET_CYCLES) begin
      reset_cnt <= reset_cnt + 1;
      rst_n     <= (reset_cnt == RESET_CYCLES - 1);
    end
  end

  // driver: one transaction per accepted start, idle gaps between
  always @(posedge clk) begin
    logic nxt_start;
    nxt_start = start;
    if (rst_n) begin
      if (start && !busy) begin
        expected_rgba.push_back(hsv_pixel_to_rgba(in_hue, in_saturation, in_brightness,
                                                  in_alpha_in));
        sent_cnt++;
        nxt_start = 1'b0;
      end
      if (!nxt_start && (have_next || pending_pixels.size() > 0)) begin
        if (!have_next) begin
          next_pixel = pending_pixels.pop_front();
          have_next  = 1'b1;
          idle_left  = next_pixel.gap;
        end
        if (idle_left == 0) begin
          in_hue        <= next_pixel.hue;
          in_saturation <= next_pixel.sat;
          in_brightness <= next_pixel.val;
          in_alpha_in   <= next_pixel.alpha;
          nxt_start     = 1'b1;
          have_next     = 1'b0;
        end else begin
          idle_left--;
        end
      end
    end
    start <= nxt_start;
  end

  // monitor: every strobe is checked against the oldest expectation
  always @(posedge clk) begin
    rgba_t want;
    if (rst_n && out_valid) begin
      if (expected_rgba.size() == 0) begin
        report_mismatch($sformatf("result with none expected (r=%0d g=%0d b=%0d a=%0d)",
                                  out_red, out_green, out_blue, out_alpha_out));
      end else begin
        want = expected_rgba.pop_front();
        checked_cnt++;
        if (out_red !== want.red)
          report_mismatch($sformatf("red got %0d expected %0d", out_red, want.red));
        if (out_green !== want.green)
          report_mismatch($sformatf("green got %0d expected %0d", out_green, want.green));
        if (out_blue !== want.blue)
          report_mismatch($sformatf("blue got %0d expected %0d", out_blue, want.blue));
        if (out_alpha_out !== want.alpha)
          report_mismatch($sformatf("alpha got %0d expected %0d", out_alpha_out, want.alpha));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected", cycle_cnt,
               expected_rgba.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic idle_phase;
    idle_phase = 1'b0;

    // directed: sector edges, wrap, zero and full saturation, over-range fields
    queue_pixel(0,     256, 256, 256, 0);
    queue_pixel(3839,  256, 256, 0,   0);
    queue_pixel(3840,  256, 256, 511, 0);
    queue_pixel(7680,  256, 200, 128, 0);
    queue_pixel(11520, 128, 256, 1,   1);
    queue_pixel(15360, 256, 256, 255, 0);
    queue_pixel(19200, 256, 256, 256, 0);
    queue_pixel(23039, 256, 256, 256, 0);
    queue_pixel(23040, 256, 256, 256, 2);
    queue_pixel(32767, 200, 180, 300, 0);
    queue_pixel(1920,  0,   123, 77,  0);
    queue_pixel(9000,  0,   511, 0,   0);
    queue_pixel(5000,  1,   256, 256, 0);
    queue_pixel(13000, 255, 256, 256, 0);
    queue_pixel(17000, 257, 256, 256, 0);
    queue_pixel(21000, 511, 256, 256, 3);
    queue_pixel(2000,  256, 0,   256, 0);
    queue_pixel(6000,  256, 257, 256, 0);
    queue_pixel(10000, 256, 511, 256, 0);
    queue_pixel(14000, 170, 1,   2,   0);
    queue_pixel(18000, 300, 300, 400, 0);
    queue_pixel(22000, 99,  255, 510, 0);
    queue_pixel(16383, 256, 256, 256, 0);
    queue_pixel(16384, 256, 256, 256, 0);

    // random pixels, idle or quiet phase picked at random every 64 pixels
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if (i % 64 == 0) idle_phase = ($urandom_range(0, 2) != 0);
      queue_pixel(pick_hue(), pick_q18(), pick_q18(), $urandom_range(0, 511),
                  pick_gap(idle_phase));
    end

    // wait for all transactions, then for the pipeline to empty
    @(posedge clk);
    while (!(rst_n && !have_next && pending_pixels.size() == 0 && !start &&
             expected_rgba.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_rgba.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_rgba.size()));
    $display("Sent %0d pixels (all hue sectors, wrapped hues, grey and over-range Q1.8 inputs),",
             sent_cnt);
    $display("checked %0d results, %0d mismatches", checked_cnt, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
